/* sv/fsmc_pkg.sv */
`default_nettype none

package fsmc_pkg;

	// Field widths fixed by the command and result formats
	localparam int CMD_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int DUTY_W   = 10;
	localparam int MODE_W   = 2;
	localparam int TMO_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MID  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HIGH = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH   = 3'd4;

	// Register reset values
	localparam logic [DUTY_W-1:0] FULL_DUTY_RST  = 10'd879;
	localparam logic [TMO_W-1:0]  IDLE_TMO_RST   = 16'd25;
	localparam logic [DUTY_W-1:0] LEVEL_LOW_RST  = 10'd263;
	localparam logic [DUTY_W-1:0] LEVEL_MID_RST  = 10'd527;
	localparam logic [DUTY_W-1:0] LEVEL_HIGH_RST = 10'd791;

	// Curve: n = 990*r - 162*2^SB, d = floor(floor(n*fd / 2^SB) / 100).
	// The scaled value is below 828*1024 < 2^20 for every sample width, so a
	// reciprocal of 2^28/100 rounded up gives the exact quotient.
	localparam int RAW_GAIN_W  = 10;
	localparam logic [RAW_GAIN_W-1:0] RAW_GAIN = 10'd990;
	localparam int OFFSET_MUL  = 162;
	localparam int SCALED_W    = 20;
	localparam int RECIP_W     = 22;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 22'd2684355;
	localparam int RECIP_SHIFT = 28;
	localparam int QUOT_W      = 14;

	// Control from the sequencer to the curve unit
	typedef struct packed {
		logic start;
		logic ack;
	} curve_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CURVE,
		ST_RESULT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		STEP_IDLE,
		STEP_SCALE,
		STEP_RECIP,
		STEP_DONE
	} curve_step_t;

endpackage

`default_nettype wire

/* sv/fsmc_if.sv */
`default_nettype none

// Command channel
interface fsmc_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [fsmc_pkg::CMD_W-1:0]    command;
	logic [fsmc_pkg::SAMPLE_W-1:0] sample;
	logic                          motion;

	modport source (output valid, output command, output sample, output motion, input ready);
	modport sink   (input valid, input command, input sample, input motion, output ready);
endinterface

// Result channel
interface fsmc_res_if;
	logic                          valid;
	logic                          ready;
	logic [fsmc_pkg::DUTY_W-1:0]   duty;
	logic                          duty_changed;
	logic                          led_on;
	logic                          idle_off;
	logic [fsmc_pkg::MODE_W-1:0]   mode_now;

	modport source (output valid, output duty, output duty_changed, output led_on,
		output idle_off, output mode_now, input ready);
	modport sink   (input valid, input duty, input duty_changed, input led_on,
		input idle_off, input mode_now, output ready);
endinterface

`default_nettype wire

/* sv/fsmc_curve.sv */
`default_nettype none

module fsmc_curve #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fsmc_pkg::curve_ctl_t        ctl,
	input  wire logic [SAMPLE_BITS-1:0]      raw,
	input  wire logic [fsmc_pkg::DUTY_W-1:0] full_duty,
	output logic                             done,
	output logic [fsmc_pkg::DUTY_W-1:0]      duty
);
	import fsmc_pkg::*;

	localparam int N_W  = SAMPLE_BITS + 10;
	localparam int WA   = (N_W > SCALED_W) ? N_W : SCALED_W;
	localparam int WB   = RECIP_W;
	localparam int PW   = WA + WB;
	localparam logic [WA-1:0] OFFSET = WA'(OFFSET_MUL) << SAMPLE_BITS;

	curve_step_t step_q, step_d;
	logic [PW-1:0] prod_q;
	logic          neg_q;
	logic [WA-1:0] op_a;
	logic [WB-1:0] op_b;
	logic          mul_en;
	logic [WA-1:0] n_val;
	logic [QUOT_W-1:0] quot;
	logic [QUOT_W-1:0] fd_ext;

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Sequencer and operand select for the shared multiplier
	always_comb begin
		step_d = step_q;
		op_a   = WA'(raw);
		op_b   = WB'(RAW_GAIN);
		mul_en = 1'b0;
		unique case (step_q)
			STEP_IDLE: begin
				if (ctl.start) begin
					mul_en = 1'b1;
					step_d = STEP_SCALE;
				end
			end
			STEP_SCALE: begin
				op_a   = n_val;
				op_b   = WB'(full_duty);
				mul_en = 1'b1;
				step_d = STEP_RECIP;
			end
			STEP_RECIP: begin
				op_a   = WA'(prod_q[SAMPLE_BITS +: SCALED_W]);
				op_b   = RECIP_MUL;
				mul_en = 1'b1;
				step_d = STEP_DONE;
			end
			STEP_DONE: begin
				if (ctl.ack) begin
					step_d = STEP_IDLE;
				end
			end
			default: step_d = STEP_IDLE;
		endcase
	end

	// Offset removal; the product is below 2^WA at this step
	assign n_val = prod_q[WA-1:0] - OFFSET;

	// Shared multiplier with product register
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PW'(op_a) * PW'(op_b);
		end
		if (step_q == STEP_SCALE) begin
			neg_q <= (prod_q[WA-1:0] < OFFSET);
		end
	end

	// Quotient, clamp to full scale, zero for a negative curve value
	assign quot   = prod_q[RECIP_SHIFT +: QUOT_W];
	assign fd_ext = QUOT_W'(full_duty);
	assign done   = (step_q == STEP_DONE);

	always_comb begin
		if (neg_q) begin
			duty = '0;
		end else if (quot > fd_ext) begin
			duty = full_duty;
		end else begin
			duty = quot[DUTY_W-1:0];
		end
	end

	// A start only lands on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> step_q == STEP_IDLE)
		else $error("curve start while busy");

	// The result never exceeds full scale
	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> duty <= full_duty)
		else $error("curve duty above full scale");

	// An acknowledge only follows a finished result
	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ack |-> done)
		else $error("curve acknowledged before done");

endmodule

`default_nettype wire

/* sv/fan_speed_mode_controller.sv */
`default_nettype none

// Fan speed mode controller. Each command transaction (temperature sample,
// button press or timer tick) yields exactly one result transaction with the
// duty, the change flag, LED, auto-off flag and mode after the command. A
// sample in auto mode with auto-off clear runs three passes through one shared
// multiplier (gain, full-scale product, reciprocal of 100): the first starts at
// the acceptance edge, and the result register loads once the third pass is done
// and the output slot is free; the command side is ready again as it loads. Every
// other command loads the result from the ST_RESULT state once the slot is free.
// The command side is not ready while a command is in work; a result waiting at
// the output delays only the finish of the next command. The user must write registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module fan_speed_mode_controller #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fsmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fsmc_pkg::CFG_DATA_W-1:0] cfg_data,
	fsmc_cmd_if.sink                             cmd,
	fsmc_res_if.source                           res
);
	import fsmc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;

	// Configuration registers
	logic [DUTY_W-1:0] full_duty_q;
	logic [TMO_W-1:0]  idle_timeout_q;
	logic [DUTY_W-1:0] level_low_q;
	logic [DUTY_W-1:0] level_mid_q;
	logic [DUTY_W-1:0] level_high_q;

	// Block state
	logic [MODE_W-1:0]     mode_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  idle_off_q;
	logic                  led_q;
	logic [DUTY_W-1:0]     duty_q;
	logic [CMD_W-1:0]      cmd_q;

	ctrl_state_t state_q, state_d;

	// Result register
	logic              res_valid_q;
	logic [DUTY_W-1:0] res_duty_q;
	logic              res_changed_q;
	logic              res_led_q;
	logic              res_idle_off_q;
	logic [MODE_W-1:0] res_mode_q;

	logic                  cmd_fire;
	logic                  curve_path;
	logic                  slot_free;
	logic                  out_load;
	logic [DUTY_W-1:0]     duty_next;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  count_hit;
	curve_ctl_t            curve_ctl;
	logic                  curve_done;
	logic [DUTY_W-1:0]     curve_duty;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign curve_path = (cmd.command == CMD_SAMPLE) && (mode_q == MODE_AUTO) && !idle_off_q;
	assign slot_free  = !res_valid_q || res.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_duty_q    <= FULL_DUTY_RST;
			idle_timeout_q <= IDLE_TMO_RST;
			level_low_q    <= LEVEL_LOW_RST;
			level_mid_q    <= LEVEL_MID_RST;
			level_high_q   <= LEVEL_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FULL_DUTY:    full_duty_q    <= cfg_data[DUTY_W-1:0];
				REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data[TMO_W-1:0];
				REG_LEVEL_LOW:    level_low_q    <= cfg_data[DUTY_W-1:0];
				REG_LEVEL_MID:    level_mid_q    <= cfg_data[DUTY_W-1:0];
				REG_LEVEL_HIGH:   level_high_q   <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Watchdog count with saturation
	assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;
	assign count_hit = CMP_W'(count_inc) >= CMP_W'(idle_timeout_q);

	// Mode, LED and watchdog update at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_AUTO;
			led_q      <= 1'b0;
			count_q    <= '0;
			idle_off_q <= 1'b0;
			cmd_q      <= CMD_SAMPLE;
		end else if (cmd_fire) begin
			cmd_q <= cmd.command;
			case (cmd.command)
				CMD_BUTTON: begin
					if (mode_q == MODE_AUTO) begin
						led_q <= 1'b1;
					end else if (mode_q == MODE_HIGH) begin
						led_q <= 1'b0;
					end
					mode_q <= mode_q + 1'b1;
				end
				CMD_TICK: begin
					if (cmd.motion) begin
						count_q    <= '0;
						idle_off_q <= 1'b0;
					end else begin
						count_q <= count_inc;
						if (count_hit) begin
							idle_off_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		out_load        = 1'b0;
		curve_ctl.start = 1'b0;
		curve_ctl.ack   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					curve_ctl.start = curve_path;
					state_d = curve_path ? ST_CURVE : ST_RESULT;
				end
			end
			ST_CURVE: begin
				if (curve_done && slot_free) begin
					out_load      = 1'b1;
					curve_ctl.ack = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Next duty for a sample; other commands keep it
	always_comb begin
		duty_next = duty_q;
		if (cmd_q == CMD_SAMPLE) begin
			unique case (mode_q)
				MODE_AUTO: duty_next = (state_q == ST_CURVE) ? curve_duty : '0;
				MODE_LOW:  duty_next = level_low_q;
				MODE_MID:  duty_next = level_mid_q;
				MODE_HIGH: duty_next = level_high_q;
				default:   duty_next = duty_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
		end else if (out_load) begin
			duty_q <= duty_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_duty_q     <= duty_next;
			res_changed_q  <= (duty_next != duty_q);
			res_led_q      <= led_q;
			res_idle_off_q <= idle_off_q;
			res_mode_q     <= mode_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.duty         = res_duty_q;
	assign res.duty_changed = res_changed_q;
	assign res.led_on       = res_led_q;
	assign res.idle_off     = res_idle_off_q;
	assign res.mode_now     = res_mode_q;

	// Auto curve unit
	fsmc_curve #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (curve_ctl),
		.raw       (cmd.sample[SAMPLE_BITS-1:0]),
		.full_duty (full_duty_q),
		.done      (curve_done),
		.duty      (curve_duty)
	);

	// Mode moves only on an accepted button press
	a_mode_button: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != $past(mode_q)) |-> $past(cmd_fire && cmd.command == CMD_BUTTON))
		else $error("mode changed without a button press");

	// Auto-off engages only on a tick without motion
	a_idle_off_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(idle_off_q) |-> $past(cmd_fire && cmd.command == CMD_TICK && !cmd.motion))
		else $error("auto-off set outside a quiet tick");

	// A result is loaded only for a command in work, never over a waiting one
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q != ST_IDLE) && slot_free)
		else $error("result load outside a busy state");

endmodule

`default_nettype wire
